>>> rtl/tlbri_pkg.sv
// Shared types, sizes and codes of the translation buffer refill and invalidate block.
package tlbri_pkg;

    // Table geometry
    localparam int ENTRIES    = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    // Field widths fixed by the interface
    localparam int PAGE_W     = 20;
    localparam int COUNT_W    = 21;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int CLR_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 21;
    localparam int CLR_MAX    = 127;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT    = 2'd0;
    localparam logic [OP_W-1:0] OP_INV_ALL   = 2'd1;
    localparam logic [OP_W-1:0] OP_INV_FRAME = 2'd2;

    // Result event codes
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FRAME = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT = 1'd1;

    // Stored part of a translation entry (valid bits live in flops)
    typedef struct packed {
        logic [PAGE_W-1:0] vpage;
        logic [PAGE_W-1:0] frame;
        logic              writable;
    } t_entry;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_WRITE,
        S_CLR_SCAN,
        S_FRM_SCAN,
        S_FRM_DRAIN,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic            load;
        logic [OP_W-1:0] op;
        logic            ins_step;
        logic            ins_commit;
        logic            clr_step;
        logic            frm_issue;
        logic            emit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic free_hit;
        logic last;
    } t_sts;

endpackage

>>> rtl/tlb_refill_and_invalidate_core.sv
// Top level of the translation buffer refill and invalidate block.
//
// Usage: raise start with opcode, virtual page and physical frame while busy is
// low; the item is taken at that clock edge. Opcode insert maps a page into the
// lowest free slot, or into the round-robin victim when all slots are valid.
// Invalidate-all clears every entry, invalidate-frame clears entries of a frame.
// The unused opcode is taken and dropped with no result and no busy cycle.
// Each item gives one result, shown for one cycle with o_valid high; the
// receiver cannot hold it off and needs none of its own storage beyond that.
// Busy is high after the start edge until o_valid shows, so a new item can
// follow as o_valid shows. The scan steps one entry per cycle over the valid
// bits and, for invalidate-frame, over the entry RAM read port. Configuration
// (code region base and page count) is written through i_cfg_we, i_cfg_idx and
// i_cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. Synchronous active-low reset invalidates all
// entries, zeroes the victim pointer and the region.
module tlb_refill_and_invalidate_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tlbri_pkg::OP_W-1:0]          i_opcode,
    input  logic [tlbri_pkg::PAGE_W-1:0]        i_virtual_page,
    input  logic [tlbri_pkg::PAGE_W-1:0]        i_physical_frame,
    input  logic                                i_cfg_we,
    input  logic [tlbri_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tlbri_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                                o_valid,
    output logic [tlbri_pkg::KIND_W-1:0]        o_event_kind,
    output logic [tlbri_pkg::SLOT_W-1:0]        o_slot_written,
    output logic [tlbri_pkg::CLR_W-1:0]         o_entries_cleared
);

    tlbri_pkg::t_cmd cmd;
    tlbri_pkg::t_sts sts;

    tlbri_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    tlbri_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_virtual_page    (i_virtual_page),
        .i_physical_frame  (i_physical_frame),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .o_event_kind      (o_event_kind),
        .o_slot_written    (o_slot_written),
        .o_entries_cleared (o_entries_cleared)
    );

endmodule

>>> rtl/tlbri_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlbri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tlbri_ctrl.sv
// Controller state machine that sequences insert and invalidate scans.
module tlbri_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tlbri_pkg::OP_W-1:0]  i_opcode,
    input  tlbri_pkg::t_sts             i_sts,
    output logic                        o_busy,
    output tlbri_pkg::t_cmd             o_cmd
);

    tlbri_pkg::t_state r_state;
    tlbri_pkg::t_state n_state;
    logic              accept;

    assign accept = i_start && (r_state == tlbri_pkg::S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tlbri_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_opcode)
                        tlbri_pkg::OP_INSERT:    n_state = tlbri_pkg::S_INS_SCAN;
                        tlbri_pkg::OP_INV_ALL:   n_state = tlbri_pkg::S_CLR_SCAN;
                        tlbri_pkg::OP_INV_FRAME: n_state = tlbri_pkg::S_FRM_SCAN;
                        default:                 n_state = tlbri_pkg::S_IDLE;
                    endcase
                end
            end
            tlbri_pkg::S_INS_SCAN: begin
                if (i_sts.free_hit || i_sts.last) begin
                    n_state = tlbri_pkg::S_INS_WRITE;
                end
            end
            tlbri_pkg::S_INS_WRITE: n_state = tlbri_pkg::S_IDLE;
            tlbri_pkg::S_CLR_SCAN: begin
                if (i_sts.last) begin
                    n_state = tlbri_pkg::S_FINISH;
                end
            end
            tlbri_pkg::S_FRM_SCAN: begin
                if (i_sts.last) begin
                    n_state = tlbri_pkg::S_FRM_DRAIN;
                end
            end
            tlbri_pkg::S_FRM_DRAIN: n_state = tlbri_pkg::S_FINISH;
            tlbri_pkg::S_FINISH:    n_state = tlbri_pkg::S_IDLE;
            default:                n_state = tlbri_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd     = '0;
        o_cmd.op  = i_opcode;
        o_busy    = 1'b1;
        unique case (r_state)
            tlbri_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = accept;
            end
            tlbri_pkg::S_INS_SCAN:  o_cmd.ins_step = 1'b1;
            tlbri_pkg::S_INS_WRITE: begin
                o_cmd.ins_commit = 1'b1;
                o_cmd.emit       = 1'b1;
            end
            tlbri_pkg::S_CLR_SCAN:  o_cmd.clr_step  = 1'b1;
            tlbri_pkg::S_FRM_SCAN:  o_cmd.frm_issue = 1'b1;
            tlbri_pkg::S_FRM_DRAIN: o_cmd.emit      = 1'b0;
            tlbri_pkg::S_FINISH:    o_cmd.emit      = 1'b1;
            default:                o_busy          = 1'b1;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbri_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/tlbri_dp.sv
// Datapath: valid bits, entry RAM, scan index, victim pointer, config and result registers.
module tlbri_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tlbri_pkg::t_cmd                   i_cmd,
    input  logic [tlbri_pkg::PAGE_W-1:0]      i_virtual_page,
    input  logic [tlbri_pkg::PAGE_W-1:0]      i_physical_frame,
    input  logic                              i_cfg_we,
    input  logic [tlbri_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlbri_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output tlbri_pkg::t_sts                   o_sts,
    output logic                              o_valid,
    output logic [tlbri_pkg::KIND_W-1:0]      o_event_kind,
    output logic [tlbri_pkg::SLOT_W-1:0]      o_slot_written,
    output logic [tlbri_pkg::CLR_W-1:0]       o_entries_cleared
);

    localparam int ENTRIES = tlbri_pkg::ENTRIES;
    localparam int IDX_W   = tlbri_pkg::IDX_W;
    localparam int CNT_W   = tlbri_pkg::CNT_W;
    localparam int PAGE_W  = tlbri_pkg::PAGE_W;

    logic [ENTRIES-1:0]               r_valid;
    logic [PAGE_W-1:0]                r_vpage;
    logic [PAGE_W-1:0]                r_frame;
    logic [IDX_W-1:0]                 r_idx;
    logic [IDX_W-1:0]                 r_cmp_idx;
    logic                             r_cmp_en;
    logic [IDX_W-1:0]                 r_slot;
    logic [IDX_W-1:0]                 r_victim;
    logic [CNT_W-1:0]                 r_cleared;
    logic [tlbri_pkg::KIND_W-1:0]     r_kind;
    logic [PAGE_W-1:0]                r_code_base;
    logic [tlbri_pkg::COUNT_W-1:0]    r_code_count;
    logic                             r_out_valid;
    logic [tlbri_pkg::KIND_W-1:0]     r_out_kind;
    logic [tlbri_pkg::SLOT_W-1:0]     r_out_slot;
    logic [tlbri_pkg::CLR_W-1:0]      r_out_cleared;

    logic                             last;
    logic                             frm_hit;
    logic [IDX_W-1:0]                 victim_next;
    logic [PAGE_W-1:0]                page_off;
    logic                             in_code;
    logic [tlbri_pkg::CLR_W-1:0]      cleared_sat;
    tlbri_pkg::t_entry                wr_entry;
    tlbri_pkg::t_entry                rd_entry;

    // Scan status
    assign last            = (r_idx == IDX_W'(ENTRIES - 1));
    assign o_sts.last      = last;
    assign o_sts.free_hit  = !r_valid[r_idx];

    // Round-robin victim advance
    assign victim_next = (r_victim == IDX_W'(ENTRIES - 1)) ? '0 : r_victim + IDX_W'(1);

    // Code region check: base <= page < base + count, without overflow
    assign page_off = r_vpage - r_code_base;
    assign in_code  = (r_vpage >= r_code_base) &&
                      ({1'b0, page_off} < r_code_count);

    assign wr_entry.vpage    = r_vpage;
    assign wr_entry.frame    = r_frame;
    assign wr_entry.writable = !in_code;

    // Frame match on the entry whose read was issued in the previous cycle
    assign frm_hit = r_cmp_en && r_valid[r_cmp_idx] && (rd_entry.frame == r_frame);

    // Saturate the cleared count for the result field
    assign cleared_sat = (32'(r_cleared) > 32'(tlbri_pkg::CLR_MAX)) ?
                         tlbri_pkg::CLR_W'(tlbri_pkg::CLR_MAX) :
                         tlbri_pkg::CLR_W'(r_cleared);

    tlbri_ram #(
        .WIDTH ($bits(tlbri_pkg::t_entry)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_commit),
        .i_waddr (r_slot),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.frm_issue),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_base  <= '0;
            r_code_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlbri_pkg::REG_CODE_BASE:  r_code_base  <= PAGE_W'(i_cfg_wdata);
                tlbri_pkg::REG_CODE_COUNT: r_code_count <= tlbri_pkg::COUNT_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // Valid bits and victim pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_victim <= '0;
        end else begin
            if (i_cmd.ins_step && r_valid[r_idx] && last) begin
                r_victim <= victim_next;
            end
            if (i_cmd.ins_commit) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (frm_hit) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end
        end
    end

    // Read pipeline tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_en <= 1'b0;
        end else begin
            r_cmp_en <= i_cmd.frm_issue;
        end
    end

    // Item registers, scan index, count and outcome
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (i_cmd.load) begin
            r_vpage   <= i_virtual_page;
            r_frame   <= i_physical_frame;
            r_idx     <= '0;
            r_slot    <= '0;
            r_cleared <= '0;
            r_kind    <= (i_cmd.op == tlbri_pkg::OP_INV_ALL) ? tlbri_pkg::KIND_ALL :
                                                              tlbri_pkg::KIND_FRAME;
        end
        if (i_cmd.ins_step) begin
            if (!r_valid[r_idx]) begin
                r_slot <= r_idx;
                r_kind <= tlbri_pkg::KIND_FREE;
            end else if (last) begin
                r_slot    <= r_victim;
                r_kind    <= tlbri_pkg::KIND_REPL;
                r_cleared <= CNT_W'(1);
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
        if (i_cmd.clr_step) begin
            r_idx <= r_idx + IDX_W'(1);
            if (r_valid[r_idx]) begin
                r_cleared <= r_cleared + CNT_W'(1);
            end
        end
        if (i_cmd.frm_issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (frm_hit) begin
            r_cleared <= r_cleared + CNT_W'(1);
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind    <= r_kind;
            r_out_slot    <= tlbri_pkg::SLOT_W'(r_slot);
            r_out_cleared <= cleared_sat;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_event_kind      = r_out_kind;
    assign o_slot_written    = r_out_slot;
    assign o_entries_cleared = r_out_cleared;

endmodule
